// ===== hdl/dda_pkg.sv =====
package dda_pkg;

  localparam int COORD_BITS_DEF = 10;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH    = 2;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_NEXT = 1'b1
  } func_e;

  typedef enum logic {
    BK_IDLE,
    BK_DIV
  } back_state_e;

endpackage

// ===== hdl/dda_line_rasterizer.sv =====
// DDA line generator. A load beat (func_i = 0) takes a start and end point and
// returns the start pixel; each following next beat (func_i = 1) returns the
// next pixel along the major axis, rounded half up, with last_pixel_o on the
// end point. A next beat with no segment running returns pixel_valid_o = 0.
// A next beat needs no divider work. A load returns its start pixel, then,
// unless the segment has zero length, the engine runs its bit-serial divider
// forming both slopes before it takes the next beat; a two-entry queue in
// front lets loads and next beats be posted meanwhile.
// Output results sit in a register, so a stalled result does not stop the
// front end from accepting beats until the queue fills.
module dda_line_rasterizer #(
  parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = dda_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  func_i,
  input  logic [COORD_BITS-1:0] x_start_i,
  input  logic [COORD_BITS-1:0] y_start_i,
  input  logic [COORD_BITS-1:0] x_end_i,
  input  logic [COORD_BITS-1:0] y_end_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [COORD_BITS-1:0] pixel_x_o,
  output logic [COORD_BITS-1:0] pixel_y_o,
  output logic                  last_pixel_o,
  output logic                  pixel_valid_o
);

  import dda_pkg::*;

  localparam int ENTRY_BITS = 5 * COORD_BITS + 3;

  logic                  q_push, q_full, q_pop, q_empty;
  logic [ENTRY_BITS-1:0] q_wdata, q_rdata;

  dda_front #(
    .COORD_BITS (COORD_BITS),
    .ENTRY_BITS (ENTRY_BITS)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .func_i     (func_i),
    .x_start_i  (x_start_i),
    .y_start_i  (y_start_i),
    .x_end_i    (x_end_i),
    .y_end_i    (y_end_i),
    .push_o     (q_push),
    .entry_o    (q_wdata),
    .full_i     (q_full)
  );

  dda_fifo #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  dda_back #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .ENTRY_BITS (ENTRY_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_i       (q_rdata),
    .empty_i       (q_empty),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .last_pixel_o  (last_pixel_o),
    .pixel_valid_o (pixel_valid_o)
  );

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

  a_no_pop_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !q_pop)
    else $error("result overwritten while stalled");

  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> in_stall_o)
    else $error("input taken with queue full");

  a_pop_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> out_valid_o)
    else $error("popped command produced no result");

endmodule

// ===== hdl/dda_fifo.sv =====
module dda_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d;
  logic [PW-1:0]    rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    if (p == PW'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PW'(1);
    end
    return r;
  endfunction

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? ptr_inc(wptr_q) : wptr_q;
    rptr_d = pop_i ? ptr_inc(rptr_q) : rptr_q;
    cnt_d  = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

// ===== hdl/dda_front.sv =====
module dda_front #(
  parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF,
  parameter int ENTRY_BITS = 5 * COORD_BITS + 3
) (
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  func_i,
  input  logic [COORD_BITS-1:0] x_start_i,
  input  logic [COORD_BITS-1:0] y_start_i,
  input  logic [COORD_BITS-1:0] x_end_i,
  input  logic [COORD_BITS-1:0] y_end_i,
  output logic                  push_o,
  output logic [ENTRY_BITS-1:0] entry_o,
  input  logic                  full_i
);

  import dda_pkg::*;

  logic [COORD_BITS-1:0] adx, ady, step;
  logic                  x_neg, y_neg;

  // classify the segment: magnitudes, directions and the major-axis length
  always_comb begin
    x_neg = (x_end_i < x_start_i);
    y_neg = (y_end_i < y_start_i);
    adx   = x_neg ? (x_start_i - x_end_i) : (x_end_i - x_start_i);
    ady   = y_neg ? (y_start_i - y_end_i) : (y_end_i - y_start_i);
    step  = (adx > ady) ? adx : ady;
  end

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;
  assign entry_o    = {func_i, x_start_i, y_start_i, adx, ady, step, x_neg, y_neg};

endmodule

// ===== hdl/dda_back.sv =====
module dda_back #(
  parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = dda_pkg::FRAC_BITS_DEF,
  parameter int ENTRY_BITS = 5 * COORD_BITS + 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [ENTRY_BITS-1:0] entry_i,
  input  logic                  empty_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [COORD_BITS-1:0] pixel_x_o,
  output logic [COORD_BITS-1:0] pixel_y_o,
  output logic                  last_pixel_o,
  output logic                  pixel_valid_o
);

  import dda_pkg::*;

  localparam int ACC_BITS = COORD_BITS + FRAC_BITS;
  localparam int REM_BITS = COORD_BITS + 1;
  localparam int QUO_BITS = FRAC_BITS + 1;
  localparam int CNT_BITS = $clog2(FRAC_BITS + 1);
  // accumulators carry a half-LSB bias so the integer bits are already rounded
  localparam logic [FRAC_BITS-1:0] HALF = {1'b1, {(FRAC_BITS - 1){1'b0}}};

  logic                  e_func;
  logic [COORD_BITS-1:0] e_xs, e_ys, e_adx, e_ady, e_step;
  logic                  e_xneg, e_yneg;

  back_state_e           st_q, st_d;
  logic [ACC_BITS-1:0]   acc_x_q, acc_y_q, inc_x_q, inc_y_q;
  logic [ACC_BITS-1:0]   acc_x_nx, acc_y_nx, inc_x_fin, inc_y_fin;
  logic [COORD_BITS-1:0] left_q, dsr_q;
  logic                  active_q, neg_x_q, neg_y_q;
  logic [REM_BITS-1:0]   rem_x_q, rem_y_q, sub_x, sub_y;
  logic [QUO_BITS-1:0]   quo_x_q, quo_y_q, quo_x_d, quo_y_d;
  logic [CNT_BITS-1:0]   cnt_q;
  logic                  ge_x, ge_y;

  logic                  out_vld_q, last_q, pv_q;
  logic [COORD_BITS-1:0] px_q, py_q;

  logic out_free, is_load, is_zero, div_done;

  assign {e_func, e_xs, e_ys, e_adx, e_ady, e_step, e_xneg, e_yneg} = entry_i;

  assign out_free = !out_vld_q || !out_stall_i;
  assign is_load  = (func_e'(e_func) == FUNC_LOAD);
  assign is_zero  = (e_step == '0);
  assign div_done = (cnt_q == '0);

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      BK_IDLE: begin
        if (pop_o && is_load && !is_zero) begin
          st_d = BK_DIV;
        end
      end
      BK_DIV: begin
        if (div_done) begin
          st_d = BK_IDLE;
        end
      end
      default: st_d = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop_o = 1'b0;
    case (st_q)
      BK_IDLE: pop_o = !empty_i && out_free;
      BK_DIV:  pop_o = 1'b0;
      default: pop_o = 1'b0;
    endcase
  end

  // one restoring-division bit per cycle for each axis, shared divisor
  always_comb begin
    ge_x      = (rem_x_q >= {1'b0, dsr_q});
    ge_y      = (rem_y_q >= {1'b0, dsr_q});
    sub_x     = ge_x ? (rem_x_q - {1'b0, dsr_q}) : rem_x_q;
    sub_y     = ge_y ? (rem_y_q - {1'b0, dsr_q}) : rem_y_q;
    quo_x_d   = {quo_x_q[QUO_BITS-2:0], ge_x};
    quo_y_d   = {quo_y_q[QUO_BITS-2:0], ge_y};
    inc_x_fin = neg_x_q ? (ACC_BITS'(0) - ACC_BITS'(quo_x_d)) : ACC_BITS'(quo_x_d);
    inc_y_fin = neg_y_q ? (ACC_BITS'(0) - ACC_BITS'(quo_y_d)) : ACC_BITS'(quo_y_d);
    acc_x_nx  = acc_x_q + inc_x_q;
    acc_y_nx  = acc_y_q + inc_y_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= BK_IDLE;
      active_q  <= 1'b0;
      out_vld_q <= 1'b0;
      left_q    <= '0;
      cnt_q     <= '0;
    end else begin
      st_q <= st_d;
      if (pop_o) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      if (pop_o && is_load) begin
        active_q <= !is_zero;
        left_q   <= e_step;
        cnt_q    <= CNT_BITS'(FRAC_BITS);
      end else if (pop_o && active_q) begin
        active_q <= (left_q != COORD_BITS'(1));
        left_q   <= left_q - COORD_BITS'(1);
      end else if (st_q == BK_DIV) begin
        cnt_q <= cnt_q - CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_x_q <= '0;
      acc_y_q <= '0;
      inc_x_q <= '0;
      inc_y_q <= '0;
    end else if (pop_o && is_load) begin
      acc_x_q <= {e_xs, HALF};
      acc_y_q <= {e_ys, HALF};
      inc_x_q <= '0;
      inc_y_q <= '0;
    end else if (pop_o && active_q) begin
      acc_x_q <= acc_x_nx;
      acc_y_q <= acc_y_nx;
    end else if ((st_q == BK_DIV) && div_done) begin
      inc_x_q <= inc_x_fin;
      inc_y_q <= inc_y_fin;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && is_load) begin
      dsr_q   <= e_step;
      rem_x_q <= {1'b0, e_adx};
      rem_y_q <= {1'b0, e_ady};
      neg_x_q <= e_xneg;
      neg_y_q <= e_yneg;
      quo_x_q <= '0;
      quo_y_q <= '0;
    end else if (st_q == BK_DIV) begin
      rem_x_q <= {sub_x[REM_BITS-2:0], 1'b0};
      rem_y_q <= {sub_y[REM_BITS-2:0], 1'b0};
      quo_x_q <= quo_x_d;
      quo_y_q <= quo_y_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      if (is_load) begin
        px_q   <= e_xs;
        py_q   <= e_ys;
        last_q <= is_zero;
        pv_q   <= 1'b1;
      end else if (active_q) begin
        px_q   <= acc_x_nx[ACC_BITS-1:FRAC_BITS];
        py_q   <= acc_y_nx[ACC_BITS-1:FRAC_BITS];
        last_q <= (left_q == COORD_BITS'(1));
        pv_q   <= 1'b1;
      end else begin
        px_q   <= '0;
        py_q   <= '0;
        last_q <= 1'b0;
        pv_q   <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_vld_q;
  assign pixel_x_o     = px_q;
  assign pixel_y_o     = py_q;
  assign last_pixel_o  = last_q;
  assign pixel_valid_o = pv_q;

endmodule
